/* rtl/crd_pkg.sv */
`timescale 1ns / 1ps
package crd_pkg;

  // Canonical quiet NaN
  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // Quotient bits produced by the divider: hidden bit, 23 fraction, guard, round
  localparam int DivSteps = 26;

  // Error kinds
  localparam logic [3:0] ERR_NONE = 4'd0;
  localparam logic [3:0] ERR_L    = 4'd1;
  localparam logic [3:0] ERR_U    = 4'd2;
  localparam logic [3:0] ERR_V    = 4'd3;
  localparam logic [3:0] ERR_W    = 4'd4;
  localparam logic [3:0] ERR_T    = 4'd5;
  localparam logic [3:0] ERR_S    = 4'd6;
  localparam logic [3:0] ERR_B    = 4'd7;
  localparam logic [3:0] ERR_FW   = 4'd8;

  // Per-record data carried alongside the arithmetic
  typedef struct packed {
    logic [31:0] xb;
    logic [31:0] yb;
    logic [31:0] zb;
    logic [2:0]  rr;
    logic [2:0]  gr;
    logic [2:0]  br;
    logic [3:0]  ek;
  } rec_t;

  // Three-byte code to single; always exact
  function automatic logic [31:0] code_to_bits(input logic [23:0] c);
    logic [14:0]        m;
    logic signed [9:0]  e;
    logic [3:0]         p;
    logic signed [9:0]  ex;
    logic signed [9:0]  sh;
    logic [37:0]        t;
    logic [31:0]        b;
    m  = c[22:8];
    e  = {{2{c[7]}}, c[7:0]};
    p  = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (m[i]) p = 4'(i);
    end
    ex = $signed({6'b0, p}) + e - 10'sd16;
    sh = e + 10'sd133;
    b  = {c[23], 31'b0};
    t  = '0;
    if (m != 15'd0) begin
      if (ex >= -10'sd126) begin
        t         = 38'(m) << (5'd23 - {1'b0, p});
        b[30:23]  = 8'(ex + 10'sd127);
        b[22:0]   = t[22:0];
      end else begin
        t         = 38'(m) << sh[4:0];
        b[22:0]   = t[22:0];
      end
    end
    return b;
  endfunction

  // Range byte to three ranges {ch0, ch1, ch2}
  function automatic logic [8:0] range_decode(input logic [7:0] rb);
    logic [4:0] r;
    logic [8:0] t1;
    logic [8:0] t2;
    logic [3:0] q1;
    logic [1:0] q2;
    logic [4:0] m2;
    logic [3:0] m1;
    logic [1:0] d0;
    logic [2:0] r0;
    logic [2:0] r1;
    logic [2:0] r2;
    r  = rb[4:0];
    // divide by three through the reciprocal 11/32, exact below 32
    t1 = 9'(r) * 9'd11;
    q1 = t1[8:5];
    m2 = r - {1'b0, q1} - {q1, 1'b0};
    t2 = 9'(q1) * 9'd11;
    q2 = t2[6:5];
    m1 = q1 - {2'b0, q2} - {1'b0, q2, 1'b0};
    d0 = (q2 == 2'd3) ? 2'd0 : q2;
    r0 = 3'd1 + {2'b0, rb[7]} + {d0, 1'b0};
    r1 = 3'd1 + {2'b0, rb[6]} + {m1[1:0], 1'b0};
    r2 = 3'd1 + {2'b0, rb[5]} + {m2[1:0], 1'b0};
    return {r0, r1, r2};
  endfunction

  // Error character to kind
  function automatic logic [3:0] error_map(input logic [7:0] ch);
    logic [3:0] k;
    case (ch)
      8'h4C:   k = ERR_L;
      8'h75:   k = ERR_U;
      8'h76:   k = ERR_V;
      8'h77:   k = ERR_W;
      8'h74:   k = ERR_T;
      8'h73:   k = ERR_S;
      8'h62:   k = ERR_B;
      8'h58,
      8'h42:   k = ERR_FW;
      default: k = ERR_NONE;
    endcase
    return k;
  endfunction

  // Leading zeros of a 27-bit word, 27 when zero
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  // Leading zeros of a 24-bit word, 24 when zero
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  // Round to nearest even and pack. m holds hidden bit at [26], guard at [2],
  // round at [1], sticky at [0]; e >= 1, hidden bit clear means subnormal.
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                             input logic [26:0] m);
    logic              up;
    logic [24:0]       r;
    logic signed [10:0] ef;
    logic [31:0]       b;
    up = m[2] & (m[1] | m[0] | m[3]);
    r  = {1'b0, m[26:3]} + 25'(up);
    ef = e;
    if (r[24]) begin
      r  = r >> 1;
      ef = e + 11'sd1;
    end
    if (ef >= 11'sd255) b = {s, 8'hFF, 23'b0};
    else if (!r[23])    b = {s, 8'h00, r[22:0]};
    else                b = {s, ef[7:0], r[22:0]};
    return b;
  endfunction

endpackage

/* rtl/crd_fadd.sv */
`timescale 1ns / 1ps
module crd_fadd (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  input  crd_pkg::rec_t side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   sum,
  output crd_pkg::rec_t side_out
);
  import crd_pkg::*;

  logic [3:0] v;
  logic [3:0] en;

  // Stage advance: a stage loads when empty or when it drains onward
  always_comb begin
    en[3] = !v[3] | out_ready;
    for (int k = 2; k >= 0; k--) en[k] = !v[k] | en[k + 1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (en[k]) v[k] <= v[k - 1];
      end
    end
  end

  // Stage A: order by magnitude, align the smaller operand
  logic        swap;
  logic [31:0] big;
  logic [31:0] sml;
  logic [7:0]  ea_c;
  logic [7:0]  eb_c;
  logic [7:0]  diff;
  logic [26:0] mb_x;
  logic [26:0] lost;
  logic [26:0] al;

  always_comb begin
    swap = (b[30:0] > a[30:0]);
    big  = swap ? b : a;
    sml  = swap ? a : b;
    ea_c = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    eb_c = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    diff = ea_c - eb_c;
    mb_x = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    lost = '0;
    if (diff >= 8'd27) begin
      al = {26'b0, |mb_x};
    end else begin
      lost  = mb_x & ~({27{1'b1}} << diff[4:0]);
      al    = mb_x >> diff[4:0];
      al[0] = al[0] | (|lost);
    end
  end

  logic        a_s;
  logic        a_sub;
  logic [7:0]  a_e;
  logic [26:0] a_ma;
  logic [26:0] a_mb;
  rec_t        a_side;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_s    <= big[31];
      a_sub  <= a[31] ^ b[31];
      a_e    <= ea_c;
      a_ma   <= {(big[30:23] != 8'd0), big[22:0], 3'b000};
      a_mb   <= al;
      a_side <= side_in;
    end
  end

  // Stage B: add or subtract, count leading zeros
  logic [27:0] sum_c;
  logic        sgn_c;

  always_comb begin
    sum_c = a_sub ? ({1'b0, a_ma} - {1'b0, a_mb}) : ({1'b0, a_ma} + {1'b0, a_mb});
    sgn_c = (sum_c == 28'd0 && a_sub) ? 1'b0 : a_s;
  end

  logic [27:0] b_sum;
  logic [4:0]  b_lz;
  logic [7:0]  b_e;
  logic        b_s;
  rec_t        b_side;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_sum  <= sum_c;
      b_lz   <= lzc27(sum_c[26:0]);
      b_e    <= a_e;
      b_s    <= sgn_c;
      b_side <= a_side;
    end
  end

  // Stage C: normalise, stopping at the subnormal boundary
  logic [7:0]         lim;
  logic [7:0]         shl;
  logic [26:0]        nm;
  logic signed [10:0] ne;

  always_comb begin
    lim = b_e - 8'd1;
    shl = ({3'b0, b_lz} < lim) ? {3'b0, b_lz} : lim;
    if (b_sum[27]) begin
      nm = {b_sum[27:2], b_sum[1] | b_sum[0]};
      ne = $signed({3'b0, b_e}) + 11'sd1;
    end else if (b_sum == 28'd0) begin
      nm = '0;
      ne = 11'sd1;
    end else begin
      nm = b_sum[26:0] << shl[4:0];
      ne = $signed({3'b0, b_e}) - $signed({3'b0, shl});
    end
  end

  logic [26:0]        c_m;
  logic signed [10:0] c_e;
  logic               c_s;
  rec_t               c_side;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_m    <= nm;
      c_e    <= ne;
      c_s    <= b_s;
      c_side <= b_side;
    end
  end

  // Stage D: round and pack
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sum      <= round_pack(c_s, c_e, c_m);
      side_out <= c_side;
    end
  end

endmodule

/* rtl/crd_fdiv.sv */
`timescale 1ns / 1ps
module crd_fdiv (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [31:0]   nx,
  input  logic [31:0]   ny,
  input  logic [31:0]   den,
  input  crd_pkg::rec_t side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   qx,
  output logic [31:0]   qy,
  output crd_pkg::rec_t side_out
);
  import crd_pkg::*;

  localparam int NSt = DivSteps + 4;

  typedef enum logic [1:0] {QK_NUM, QK_ZERO, QK_INF, QK_NAN} qkind_t;

  typedef struct packed {
    logic       s;
    logic       z;
    logic [7:0] e;
    logic [4:0] lz;
    logic [23:0] m;
  } unp_t;

  typedef struct packed {
    logic               s;
    qkind_t             kind;
    logic signed [10:0] e;
    logic [24:0]        rem;
    logic [25:0]        q;
  } lane_t;

  typedef struct packed {
    logic               s;
    qkind_t             kind;
    logic signed [10:0] e;
    logic [26:0]        m;
  } fin_t;

  function automatic unp_t unpack(input logic [31:0] f);
    unp_t u;
    u.s  = f[31];
    u.m  = {(f[30:23] != 8'd0), f[22:0]};
    u.e  = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
    u.lz = lzc24(u.m);
    u.z  = (u.m == 24'd0);
    return u;
  endfunction

  function automatic lane_t start_lane(input unp_t n, input unp_t d, input logic [23:0] mdn,
                                       input logic signed [10:0] edn);
    lane_t              l;
    logic [23:0]        mn;
    logic signed [10:0] enn;
    mn    = n.m << n.lz;
    enn   = $signed({3'b0, n.e}) - $signed({6'b0, n.lz});
    l.s   = n.s ^ d.s;
    l.q   = '0;
    if (n.z && d.z) l.kind = QK_NAN;
    else if (d.z)   l.kind = QK_INF;
    else if (n.z)   l.kind = QK_ZERO;
    else            l.kind = QK_NUM;
    l.e = enn - edn + 11'sd127;
    if (mn < mdn) begin
      l.rem = {mn, 1'b0};
      l.e   = l.e - 11'sd1;
    end else begin
      l.rem = {1'b0, mn};
    end
    return l;
  endfunction

  // One restoring quotient bit
  function automatic lane_t div_step(input lane_t l, input logic [23:0] md);
    lane_t       o;
    logic        ge;
    logic [24:0] r;
    o     = l;
    ge    = (l.rem >= {1'b0, md});
    r     = ge ? (l.rem - {1'b0, md}) : l.rem;
    o.rem = {r[23:0], 1'b0};
    o.q   = {l.q[24:0], ge};
    return o;
  endfunction

  // Denormalise towards the subnormal range, folding lost bits into sticky
  function automatic fin_t finish(input lane_t l);
    fin_t               f;
    logic [26:0]        vq;
    logic [26:0]        lost;
    logic signed [10:0] sh;
    vq     = {l.q, (l.rem != 25'd0)};
    sh     = 11'sd1 - l.e;
    lost   = '0;
    f.s    = l.s;
    f.kind = l.kind;
    if (l.e >= 11'sd1) begin
      f.m = vq;
      f.e = l.e;
    end else begin
      f.e = 11'sd1;
      if (sh >= 11'sd27) begin
        f.m = {26'b0, |vq};
      end else begin
        lost   = vq & ~({27{1'b1}} << sh[4:0]);
        f.m    = vq >> sh[4:0];
        f.m[0] = f.m[0] | (|lost);
      end
    end
    return f;
  endfunction

  function automatic logic [31:0] pack_out(input fin_t f);
    logic [31:0] b;
    case (f.kind)
      QK_NAN:  b = QNAN;
      QK_INF:  b = {f.s, 8'hFF, 23'b0};
      QK_ZERO: b = {f.s, 31'b0};
      default: b = round_pack(f.s, f.e, f.m);
    endcase
    return b;
  endfunction

  logic [NSt-1:0] v;
  logic [NSt-1:0] en;

  // Stage advance chain
  always_comb begin
    en[NSt-1] = !v[NSt-1] | out_ready;
    for (int k = NSt - 2; k >= 0; k--) en[k] = !v[k] | en[k + 1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[NSt-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) v[k] <= v[k - 1];
      end
    end
  end

  // Unpack operands
  unp_t p0_x;
  unp_t p0_y;
  unp_t p0_d;
  rec_t p0_side;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0_x    <= unpack(nx);
      p0_y    <= unpack(ny);
      p0_d    <= unpack(den);
      p0_side <= side_in;
    end
  end

  // Normalise and set up the quotient exponent
  logic [23:0]        mdn;
  logic signed [10:0] edn;

  always_comb begin
    mdn = p0_d.m << p0_d.lz;
    edn = $signed({3'b0, p0_d.e}) - $signed({6'b0, p0_d.lz});
  end

  lane_t       lx [DivSteps+1];
  lane_t       ly [DivSteps+1];
  logic [23:0] md [DivSteps+1];
  rec_t        sd [DivSteps+1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lx[0] <= start_lane(p0_x, p0_d, mdn, edn);
      ly[0] <= start_lane(p0_y, p0_d, mdn, edn);
      md[0] <= mdn;
      sd[0] <= p0_side;
    end
  end

  // Quotient bit stages, both lanes share the divisor
  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[i + 2]) begin
        lx[i + 1] <= div_step(lx[i], md[i]);
        ly[i + 1] <= div_step(ly[i], md[i]);
        md[i + 1] <= md[i];
        sd[i + 1] <= sd[i];
      end
    end
  end

  // Subnormal alignment
  fin_t f_x;
  fin_t f_y;
  rec_t f_side;

  always_ff @(posedge clk) begin
    if (en[NSt-2]) begin
      f_x    <= finish(lx[DivSteps]);
      f_y    <= finish(ly[DivSteps]);
      f_side <= sd[DivSteps];
    end
  end

  // Round, special cases, output register
  always_ff @(posedge clk) begin
    if (en[NSt-1]) begin
      qx       <= pack_out(f_x);
      qy       <= pack_out(f_y);
      side_out <= f_side;
    end
  end

endmodule

/* rtl/colorimeter_record_decoder.sv */
`timescale 1ns / 1ps
// Colorimeter record decoder. Takes one record per cycle while in_stall is low and
// returns the X, Y and Z codes as IEEE singles, the chromaticities x and y
// (X and Y over the single-precision sum (X+Y)+Z, round to nearest even, NaN as
// 0x7FC00000, zero sum giving signed infinity), three gain ranges and the
// error kind. Pipeline: one decode stage, two four-stage adders and a 30-stage
// divider whose 26 restoring quotient-bit stages set the depth. Stalls on the
// output hold results while empty stages upstream keep filling.
module colorimeter_record_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] x_code,
  input  logic [23:0] y_code,
  input  logic [23:0] z_code,
  input  logic [7:0]  range_byte,
  input  logic [7:0]  error_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] x_tristim,
  output logic [31:0] y_tristim,
  output logic [31:0] z_tristim,
  output logic [31:0] x_chroma,
  output logic [31:0] y_chroma,
  output logic [2:0]  red_range,
  output logic [2:0]  green_range,
  output logic [2:0]  blue_range,
  output logic [3:0]  error_kind
);
  import crd_pkg::*;

  logic        s0_v;
  logic        s0_en;
  rec_t        s0_rec;
  logic [8:0]  rng_c;

  logic        a1_rdy;
  logic        a1_v;
  logic [31:0] a1_sum;
  rec_t        a1_side;
  logic        a2_rdy;
  logic        a2_v;
  logic [31:0] a2_sum;
  rec_t        a2_side;
  logic        dv_rdy;
  rec_t        dv_side;

  // Decode stage
  assign s0_en    = !s0_v | a1_rdy;
  assign in_stall = !s0_en;
  assign rng_c    = range_decode(range_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s0_en) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en) begin
      s0_rec.xb <= code_to_bits(x_code);
      s0_rec.yb <= code_to_bits(y_code);
      s0_rec.zb <= code_to_bits(z_code);
      s0_rec.rr <= rng_c[8:6];
      s0_rec.gr <= rng_c[5:3];
      s0_rec.br <= rng_c[2:0];
      s0_rec.ek <= error_map(error_char);
    end
  end

  // X + Y
  crd_fadd u_add1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_v),
    .in_ready  (a1_rdy),
    .a         (s0_rec.xb),
    .b         (s0_rec.yb),
    .side_in   (s0_rec),
    .out_valid (a1_v),
    .out_ready (a2_rdy),
    .sum       (a1_sum),
    .side_out  (a1_side)
  );

  // (X + Y) + Z
  crd_fadd u_add2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a1_v),
    .in_ready  (a2_rdy),
    .a         (a1_sum),
    .b         (a1_side.zb),
    .side_in   (a1_side),
    .out_valid (a2_v),
    .out_ready (dv_rdy),
    .sum       (a2_sum),
    .side_out  (a2_side)
  );

  // Chromaticities
  crd_fdiv u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a2_v),
    .in_ready  (dv_rdy),
    .nx        (a2_side.xb),
    .ny        (a2_side.yb),
    .den       (a2_sum),
    .side_in   (a2_side),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .qx        (x_chroma),
    .qy        (y_chroma),
    .side_out  (dv_side)
  );

  assign x_tristim   = dv_side.xb;
  assign y_tristim   = dv_side.yb;
  assign z_tristim   = dv_side.zb;
  assign red_range   = dv_side.rr;
  assign green_range = dv_side.gr;
  assign blue_range  = dv_side.br;
  assign error_kind  = dv_side.ek;

endmodule
